// ----- rtl/dsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_pkg: shared types, constants and lexer functions
// Word formats, token and type codes, keyword tables and the per-character
// lexer and grammar steps of the declaration recognizer.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int unsigned STRING_MAX_DEF = 148;
  localparam int unsigned TOKEN_MAX_DEF  = 255;
  localparam int unsigned NUM_KW         = 6;
  localparam int unsigned NUM_TYPE_KW    = 4;

  // token kinds
  localparam logic [3:0] TK_TYPE   = 4'd0;
  localparam logic [3:0] TK_IDENT  = 4'd1;
  localparam logic [3:0] TK_ASSIGN = 4'd2;
  localparam logic [3:0] TK_NUMBER = 4'd3;
  localparam logic [3:0] TK_STRING = 4'd4;
  localparam logic [3:0] TK_BOOL   = 4'd5;
  localparam logic [3:0] TK_SEMI   = 4'd6;
  localparam logic [3:0] TK_END    = 4'd7;
  localparam logic [3:0] TK_ERROR  = 4'd8;

  // value types
  localparam logic [1:0] VT_INT    = 2'd0;
  localparam logic [1:0] VT_FLOAT  = 2'd1;
  localparam logic [1:0] VT_STRING = 2'd2;
  localparam logic [1:0] VT_BOOL   = 2'd3;

  // verdicts
  localparam logic [1:0] VD_PENDING  = 2'd0;
  localparam logic [1:0] VD_ACCEPTED = 2'd1;
  localparam logic [1:0] VD_REJECTED = 2'd2;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // keywords: int float string bool true false
  localparam logic [0:5][0:7][7:0] KW_TEXT = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [0:5][7:0] KW_LEN = '{8'd3, 8'd5, 8'd6, 8'd4, 8'd4, 8'd5};

  typedef enum logic [2:0] {
    G_TYPE, G_ID, G_ASSIGN, G_LIT, G_SEMI, G_ACCEPT, G_REJECT
  } gram_pos_e;

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUMBER, M_STRING, M_STRFULL
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_length;
    logic       length_overflow;
    logic [1:0] verdict;
    logic [1:0] declared_type;
    logic [1:0] literal_type;
    logic       last;
  } out_word_t;

  typedef struct packed {
    gram_pos_e  gpos;
    lex_mode_e  mode;
    logic [7:0] count;
    logic [5:0] cands;
    logic       has_dot;
    logic [1:0] dtype;
    logic [1:0] ltype;
    logic       over;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    gpos: G_TYPE, mode: M_IDLE, count: 8'd0, cands: 6'h3f,
    has_dot: 1'b0, dtype: VT_INT, ltype: VT_INT, over: 1'b0
  };

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic decided(lex_state_t s);
    return s.gpos == G_ACCEPT || s.gpos == G_REJECT;
  endfunction

  // add one character to the current token
  function automatic lex_state_t lex_append(lex_state_t s, logic [7:0] c,
                                            logic [7:0] token_max);
    lex_state_t r;
    r = s;
    for (int k = 0; k < NUM_KW; k++) begin
      if (s.count >= KW_LEN[k] || KW_TEXT[k][s.count[2:0]] != c) begin
        r.cands[k] = 1'b0;
      end
    end
    if (s.count < token_max) begin
      r.count = s.count + 8'd1;
    end else begin
      r.over = 1'b1;
    end
    return r;
  endfunction

  function automatic lex_state_t gram_step(lex_state_t s, logic [3:0] kind,
                                           logic [1:0] sub);
    lex_state_t r;
    r = s;
    r.gpos = G_REJECT;
    unique case (s.gpos)
      G_TYPE: begin
        if (kind == TK_TYPE) begin
          r.dtype = sub;
          r.gpos  = G_ID;
        end
      end
      G_ID:     if (kind == TK_IDENT) r.gpos = G_ASSIGN;
      G_ASSIGN: if (kind == TK_ASSIGN) r.gpos = G_LIT;
      G_LIT: begin
        if (kind == TK_NUMBER || kind == TK_STRING || kind == TK_BOOL) begin
          r.ltype = sub;
          r.gpos  = G_SEMI;
        end
      end
      G_SEMI:   if (kind == TK_SEMI) r.gpos = G_ACCEPT;
      default:  r.gpos = s.gpos;
    endcase
    return r;
  endfunction

  function automatic out_word_t make_word(lex_state_t s, logic [3:0] kind,
                                          logic [7:0] len, logic ovf);
    out_word_t w;
    w.token_kind      = kind;
    w.token_length    = len;
    w.length_overflow = ovf;
    w.verdict         = (s.gpos == G_ACCEPT) ? VD_ACCEPTED :
                        (s.gpos == G_REJECT) ? VD_REJECTED : VD_PENDING;
    w.declared_type   = s.dtype;
    w.literal_type    = s.ltype;
    w.last            = 1'b0;
    return w;
  endfunction

  // close the pending token, report it and return to idle
  function automatic lex_state_t lex_flush(lex_state_t s, output out_word_t w);
    lex_state_t r;
    logic [3:0] kind;
    logic [1:0] sub;
    logic       ovf;
    kind = TK_STRING;
    sub  = VT_STRING;
    if (s.mode == M_WORD) begin
      kind = TK_IDENT;
      sub  = VT_INT;
      for (int k = 0; k < NUM_KW; k++) begin
        if (s.cands[k] && s.count == KW_LEN[k] && !s.over) begin
          kind = (k < NUM_TYPE_KW) ? TK_TYPE : TK_BOOL;
          sub  = (k < NUM_TYPE_KW) ? 2'(k) : VT_BOOL;
        end
      end
    end else if (s.mode == M_NUMBER) begin
      kind = TK_NUMBER;
      sub  = s.has_dot ? VT_FLOAT : VT_INT;
    end
    ovf = (s.mode == M_STRING || s.mode == M_STRFULL) ? 1'b0 : s.over;
    r = gram_step(s, kind, sub);
    w = make_word(r, kind, s.count, ovf);
    r.mode    = M_IDLE;
    r.count   = 8'd0;
    r.cands   = 6'h3f;
    r.has_dot = 1'b0;
    r.over    = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/declaration_statement_recognizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// datapath: a character word is taken into the input register, lexed from there
//   when the fifo has room, and its results are written into the result fifo
// throughput: one character word per cycle unless stalled; a character that closes
//   a token and is itself a token yields two words, drained one per cycle unless stalled
// stalls: the input stalls while the result fifo holds more than two words
// reset: asynchronous, active low; lexer and grammar return to expect-type
// ----------------------------------------------------------------------------
// declaration_statement_recognizer: character-stream declaration recognizer
// Lexes type, identifier, '=', literal, ';' one character per cycle when not
// stalled; emits token words with the running verdict, declared and literal types.
// ----------------------------------------------------------------------------
module declaration_statement_recognizer #(
  parameter int unsigned STRING_MAX = dsr_pkg::STRING_MAX_DEF,
  parameter int unsigned TOKEN_MAX  = dsr_pkg::TOKEN_MAX_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  dsr_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output dsr_pkg::out_word_t  out_data_o
);
  import dsr_pkg::*;

  localparam logic [7:0] StringMaxW = 8'(STRING_MAX);
  localparam logic [7:0] TokenMaxW  = 8'(TOKEN_MAX);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  // input register
  logic     in_valid_q, in_valid_d;
  in_word_t in_q;

  // lexer and grammar state
  lex_state_t state_q, state_d;

  // result fifo, words leave from the head entry
  out_word_t          fifo_q [FifoDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]      count_q, count_d;

  logic       room;       // space for the two words one character can make
  logic       fire;       // the registered character is processed this cycle
  logic       pop;
  out_word_t  res0, res1;
  logic [1:0] n_res;

  assign room        = count_q <= (PtrW+1)'(FifoDepth - 2);
  assign fire        = in_valid_q && room;
  assign in_stall_o  = in_valid_q && !room;
  assign out_valid_o = count_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // hold the character while the fifo has no room
  assign in_valid_d = in_stall_o ? 1'b1 : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // one character step: at most a flushed token and the character's own token
  always_comb begin
    lex_state_t s;
    out_word_t  w;
    logic [7:0] c;
    logic       consumed;
    s        = state_q;
    w        = '0;
    c        = in_q.char_code;
    consumed = 1'b0;
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;

    if (in_q.end_of_input) begin
      // pending token first, then the end word with the final verdict
      if (s.mode != M_IDLE && !decided(s)) begin
        s     = lex_flush(s, w);
        res0  = w;
        n_res = 2'd1;
      end
      if (s.gpos != G_ACCEPT) s.gpos = G_REJECT;
      w = make_word(s, TK_END, 8'd0, 1'b0);
      if (n_res == 2'd0) res0 = w;
      else res1 = w;
      n_res = n_res + 2'd1;
      s = LEX_RESET;
    end else if (!decided(s)) begin
      unique case (s.mode)
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            s        = lex_append(s, c, TokenMaxW);
            consumed = 1'b1;
          end else begin
            s     = lex_flush(s, w);
            res0  = w;
            n_res = 2'd1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c) || c == CH_DOT) begin
            if (c == CH_DOT) s.has_dot = 1'b1;
            s        = lex_append(s, c, TokenMaxW);
            consumed = 1'b1;
          end else begin
            s     = lex_flush(s, w);
            res0  = w;
            n_res = 2'd1;
          end
        end
        M_STRING: begin
          consumed = 1'b1;
          if (c == CH_QUOTE) begin
            s     = lex_flush(s, w);
            res0  = w;
            n_res = 2'd1;
          end else begin
            s = lex_append(s, c, TokenMaxW);
            if (s.count >= StringMaxW) s.mode = M_STRFULL;
          end
        end
        M_STRFULL: begin
          // a full string still takes its closing quote
          if (c == CH_QUOTE) consumed = 1'b1;
          s     = lex_flush(s, w);
          res0  = w;
          n_res = 2'd1;
        end
        default: s.mode = M_IDLE;
      endcase

      if (!consumed && !decided(s)) begin
        if (is_space(c)) begin
          // whitespace only separates tokens
        end else if (is_alpha(c)) begin
          s.mode  = M_WORD;
          s.count = 8'd0;
          s.cands = 6'h3f;
          s.over  = 1'b0;
          s       = lex_append(s, c, TokenMaxW);
        end else if (is_digit(c)) begin
          s.mode    = M_NUMBER;
          s.count   = 8'd0;
          s.has_dot = 1'b0;
          s.over    = 1'b0;
          s         = lex_append(s, c, TokenMaxW);
        end else if (c == CH_QUOTE) begin
          s.mode  = M_STRING;
          s.count = 8'd0;
          s.over  = 1'b0;
        end else begin
          // single-character tokens report on their own character
          if (c == CH_EQUAL) begin
            s = gram_step(s, TK_ASSIGN, VT_INT);
            w = make_word(s, TK_ASSIGN, 8'd1, 1'b0);
          end else if (c == CH_SEMI) begin
            s = gram_step(s, TK_SEMI, VT_INT);
            w = make_word(s, TK_SEMI, 8'd1, 1'b0);
          end else begin
            s = gram_step(s, TK_ERROR, VT_INT);
            w = make_word(s, TK_ERROR, 8'd1, 1'b0);
          end
          if (n_res == 2'd0) res0 = w;
          else res1 = w;
          n_res = n_res + 2'd1;
        end
      end
      // after a verdict the rest of the text is ignored
      if (decided(s)) s.mode = M_IDLE;
    end

    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
    state_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LEX_RESET;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // fifo pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (fire) begin
      wr_ptr_d = wr_ptr_q + PtrW'(n_res);
      count_d  = count_q + (PtrW+1)'(n_res);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (fire && n_res == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dsr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsr_checker: port-level checks for the declaration recognizer
// Watches the result channel for word framing and field consistency.
// ----------------------------------------------------------------------------
module dsr_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input dsr_pkg::out_word_t  out_data_o
);
  import dsr_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // end word closes the item with no length
  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind == TK_END |->
      out_data_o.last && out_data_o.token_length == 8'd0 &&
      !out_data_o.length_overflow && out_data_o.verdict != VD_PENDING)
    else $error("malformed end word");

  // single-character tokens are always the last word of their character
  a_single_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.token_kind == TK_ASSIGN ||
      out_data_o.token_kind == TK_SEMI || out_data_o.token_kind == TK_ERROR) |->
      out_data_o.last && out_data_o.token_length == 8'd1)
    else $error("single-character token word malformed");

  // an error token never leaves the verdict pending
  a_error_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind == TK_ERROR |->
      out_data_o.verdict == VD_REJECTED)
    else $error("error token without reject");

  // nothing comes out as reset is released
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word right after reset");

endmodule

bind declaration_statement_recognizer dsr_checker u_dsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
